/* sv/utt_pkg.sv */
// Shared types, constants and status codes of the UTF-16 to UTF-8 transcoder.
package utt_pkg;

    localparam int CAPACITY_MAX = 4096;
    localparam int CAP_W        = 12;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ILLEGAL  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // One queued work record: up to four UTF-8 bytes and an optional closing beat.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      n_data;
        logic            has_tail;
        logic [1:0]      tail_status;
    } t_cmd;

endpackage

/* sv/utt_front.sv */
// Front end: accepts code units, tracks surrogate and string state, builds work records.
module utt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [15:0]                 i_code_unit,
    input  logic                        i_end_of_input,
    input  logic [utt_pkg::CAP_W-1:0]   i_capacity,
    input  logic                        i_full,
    output logic                        o_push,
    output utt_pkg::t_cmd               o_cmd
);
    import utt_pkg::*;

    logic [9:0]       r_pending_high, n_pending_high;
    logic             r_pending_valid, n_pending_valid;
    logic [CAP_W-1:0] r_bytes_written, n_bytes_written;
    logic             r_discarding, n_discarding;

    logic        accept;
    logic        ends;
    logic        is_high;
    logic        is_low;
    logic        have_cp;
    logic        err_illegal;
    logic [20:0] cp;
    logic [2:0]  len;
    logic [CAP_W:0] cap;
    logic [CAP_W:0] room;
    logic        too_long;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign ends    = (i_code_unit == 16'd0) || i_end_of_input;
    assign is_high = (i_code_unit & 16'hfc00) == 16'hd800;
    assign is_low  = (i_code_unit & 16'hfc00) == 16'hdc00;

    // Classify the unit and form the code point it completes, if any.
    always_comb begin
        have_cp     = 1'b0;
        err_illegal = 1'b0;
        cp          = {5'd0, i_code_unit};
        if (r_pending_valid) begin
            if (is_low) begin
                have_cp = 1'b1;
                cp      = {1'b0, r_pending_high, i_code_unit[9:0]} + 21'h10000;
            end else begin
                err_illegal = 1'b1;
            end
        end else if (i_code_unit == 16'd0) begin
            have_cp = 1'b0;
        end else if (is_high) begin
            err_illegal = i_end_of_input;
        end else begin
            have_cp = 1'b1;
        end
    end

    always_comb begin
        if (cp <= 21'h7f) begin
            len = 3'd1;
        end else if (cp <= 21'h7ff) begin
            len = 3'd2;
        end else if (cp <= 21'hffff) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
    end

    // Capacity check against the bytes already written in this string.
    always_comb begin
        cap      = ({1'b0, i_capacity} < CAPACITY_MAX[CAP_W:0])
                   ? {1'b0, i_capacity} : CAPACITY_MAX[CAP_W:0];
        room     = (cap > {1'b0, r_bytes_written})
                   ? cap - {1'b0, r_bytes_written} : '0;
        too_long = room < {{(CAP_W - 2){1'b0}}, len};
    end

    // Build the work record and the next state.
    always_comb begin
        n_pending_high  = r_pending_high;
        n_pending_valid = r_pending_valid;
        n_bytes_written = r_bytes_written;
        n_discarding    = r_discarding;
        o_push          = 1'b0;
        o_cmd           = '0;
        unique case (len)
            3'd1: begin
                o_cmd.data[0] = cp[7:0];
            end
            3'd2: begin
                o_cmd.data[0] = {3'b110, cp[10:6]};
                o_cmd.data[1] = {2'b10, cp[5:0]};
            end
            3'd3: begin
                o_cmd.data[0] = {4'b1110, cp[15:12]};
                o_cmd.data[1] = {2'b10, cp[11:6]};
                o_cmd.data[2] = {2'b10, cp[5:0]};
            end
            default: begin
                o_cmd.data[0] = {5'b11110, cp[20:18]};
                o_cmd.data[1] = {2'b10, cp[17:12]};
                o_cmd.data[2] = {2'b10, cp[11:6]};
                o_cmd.data[3] = {2'b10, cp[5:0]};
            end
        endcase

        if (accept) begin
            if (r_discarding) begin
                // Drop units until the string ends.
                n_discarding = !ends;
            end else if (err_illegal || (have_cp && too_long)) begin
                o_push            = 1'b1;
                o_cmd.n_data      = 3'd0;
                o_cmd.has_tail    = 1'b1;
                o_cmd.tail_status = err_illegal ? ST_ILLEGAL : ST_TOO_LONG;
                n_pending_high    = '0;
                n_pending_valid   = 1'b0;
                n_bytes_written   = '0;
                n_discarding      = !ends;
            end else if (have_cp) begin
                o_push            = 1'b1;
                o_cmd.n_data      = len;
                o_cmd.has_tail    = i_end_of_input;
                o_cmd.tail_status = ST_OK;
                n_pending_high    = '0;
                n_pending_valid   = 1'b0;
                n_bytes_written   = i_end_of_input ? '0
                                    : r_bytes_written + {{(CAP_W - 3){1'b0}}, len};
            end else if (i_code_unit == 16'd0) begin
                o_push            = 1'b1;
                o_cmd.n_data      = 3'd0;
                o_cmd.has_tail    = 1'b1;
                o_cmd.tail_status = ST_OK;
                n_pending_high    = '0;
                n_pending_valid   = 1'b0;
                n_bytes_written   = '0;
            end else begin
                // Hold the high surrogate for the next unit.
                n_pending_high  = i_code_unit[9:0];
                n_pending_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_high  <= '0;
            r_pending_valid <= 1'b0;
            r_bytes_written <= '0;
            r_discarding    <= 1'b0;
        end else begin
            r_pending_high  <= n_pending_high;
            r_pending_valid <= n_pending_valid;
            r_bytes_written <= n_bytes_written;
            r_discarding    <= n_discarding;
        end
    end

endmodule

/* sv/utt_queue.sv */
// Short queue of work records between the front and back ends.
module utt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output utt_pkg::t_cmd o_cmd
);
    import utt_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == QUEUE_DEPTH[QUEUE_CW-1:0];
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* sv/utt_back.sv */
// Back end: walks each work record and drives one output beat per cycle while the output is not stalled.
module utt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  utt_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic [1:0]    o_status,
    output logic          o_end_of_string
);
    import utt_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic [1:0] r_status;
    logic       r_eos;
    logic [2:0] r_idx, n_idx;
    logic       advance;
    logic       load;
    logic [2:0] beats;
    logic       is_data;
    logic       last;

    assign advance = !r_valid || !i_stall;
    assign load    = advance && !i_empty;
    assign beats   = i_cmd.n_data + {2'b00, i_cmd.has_tail};
    assign is_data = r_idx < i_cmd.n_data;
    assign last    = r_idx == beats - 3'd1;
    assign o_pop   = load && last;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (advance) begin
            n_valid = !i_empty;
        end
        if (load) begin
            n_idx = last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= is_data ? i_cmd.data[r_idx[1:0]] : 8'd0;
            r_status <= is_data ? ST_OK : i_cmd.tail_status;
            r_eos    <= !is_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_status        = r_status;
    assign o_end_of_string = r_eos;

endmodule

/* sv/utf16_to_utf8_transcoder.sv */
// UTF-16 to UTF-8 transcoder: front end, work queue, back end and capacity register.
// The first beat of a unit's results is written to the queue, then to the output register.
// Throughput: one unit per cycle is accepted while the four-entry queue has room; the back
// end sends one byte per cycle while not stalled, so the sustained rate depends on the
// number of beats each unit causes. Reset (synchronous, active low) empties the queue
// and output, clears surrogate and string state, and sets the capacity to 1024.
module utf16_to_utf8_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_input,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_end_of_string,
    // Configuration write channel: output capacity in bytes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);
    import utt_pkg::*;

    logic [CAP_W-1:0] r_output_capacity;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    t_cmd             front_cmd;
    t_cmd             head_cmd;

    // The capacity register takes a beat in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_capacity <= CAP_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_output_capacity <= i_cfg_data;
        end
    end

    // Front end: classify each unit, update string state, queue its beats.
    utt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code_unit    (i_code_unit),
        .i_end_of_input (i_end_of_input),
        .i_capacity     (r_output_capacity),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // Decouple the two ends so each stalls on its own.
    utt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Back end: serialize bytes and the closing beat into the output register.
    utt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_status        (o_status),
        .o_end_of_string (o_end_of_string)
    );

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the UTF-16 to UTF-8 transcoder with its own encoder model.
`timescale 1ns / 100ps

module tb_top;
    import utt_pkg::*;

    // One expected output beat of the transcoder
    typedef struct {
        logic [7:0] data;
        logic [1:0] status;
        logic       eos;
    } t_utf8_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_code_unit;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_end_of_string;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data;

    // Encoder model state, updated at every accepted unit or capacity write
    logic [11:0] cap_reg;
    logic [9:0]  held_high;
    logic        held_valid;
    logic [11:0] string_bytes;
    logic        dropping;

    t_utf8_beat  utf8_beats_due[$];
    int          mismatches;
    int          units_sent;
    bit          quiet;     // no random idling on either side
    int          hold_req;  // long receiver hold-off, picked up by the receiver process

    utf16_to_utf8_transcoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_unit     (i_code_unit),
        .i_end_of_input  (i_end_of_input),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_status        (o_status),
        .o_end_of_string (o_end_of_string),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop: far beyond the slowest legal run
    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------
    // Encoder model
    // ---------------------------------------------------------------
    task automatic push_beat(input logic [7:0] data, input logic [1:0] status,
                             input logic eos);
        t_utf8_beat b;
        b.data   = data;
        b.status = status;
        b.eos    = eos;
        utf8_beats_due.push_back(b);
    endtask

    task automatic close_string();
        string_bytes = '0;
        held_high    = '0;
        held_valid   = 1'b0;
    endtask

    // Work out the beats that one accepted code unit causes
    task automatic encode_unit(input logic [15:0] unit, input logic eoi);
        logic        ends;
        logic [20:0] cp;
        logic [1:0]  err;
        int          len;
        int          cap_lim;
        int          room;
        ends = (unit == 16'h0000) || eoi;
        err  = ST_OK;
        cp   = '0;
        len  = 0;
        // Drop everything up to the end of a string that already failed
        if (dropping) begin
            if (ends)
                dropping = 1'b0;
            return;
        end
        if (held_valid) begin
            if (unit[15:10] == 6'b110111) begin
                cp = {held_high, unit[9:0]} + 21'h10000;
                held_valid = 1'b0;
                held_high  = '0;
            end else begin
                err = ST_ILLEGAL;
            end
        end else if (unit == 16'h0000) begin
            push_beat(8'h00, ST_OK, 1'b1);
            close_string();
            return;
        end else if (unit[15:10] == 6'b110110) begin
            if (eoi) begin
                err = ST_ILLEGAL;
            end else begin
                held_high  = unit[9:0];
                held_valid = 1'b1;
                return;
            end
        end else begin
            cp = {5'b0, unit};
        end

        if (err == ST_OK) begin
            len = (cp <= 21'h7f) ? 1 : (cp <= 21'h7ff) ? 2 : (cp <= 21'hffff) ? 3 : 4;
            cap_lim = (int'(cap_reg) < CAPACITY_MAX) ? int'(cap_reg) : CAPACITY_MAX;
            room = (cap_lim > int'(string_bytes)) ? cap_lim - int'(string_bytes) : 0;
            if (room < len)
                err = ST_TOO_LONG;
        end

        if (err != ST_OK) begin
            push_beat(8'h00, err, 1'b1);
            close_string();
            dropping = !ends;
            return;
        end

        case (len)
            1: begin
                push_beat(cp[7:0], ST_OK, 1'b0);
            end
            2: begin
                push_beat({3'b110, cp[10:6]}, ST_OK, 1'b0);
                push_beat({2'b10, cp[5:0]}, ST_OK, 1'b0);
            end
            3: begin
                push_beat({4'b1110, cp[15:12]}, ST_OK, 1'b0);
                push_beat({2'b10, cp[11:6]}, ST_OK, 1'b0);
                push_beat({2'b10, cp[5:0]}, ST_OK, 1'b0);
            end
            default: begin
                push_beat({5'b11110, cp[20:18]}, ST_OK, 1'b0);
                push_beat({2'b10, cp[17:12]}, ST_OK, 1'b0);
                push_beat({2'b10, cp[11:6]}, ST_OK, 1'b0);
                push_beat({2'b10, cp[5:0]}, ST_OK, 1'b0);
            end
        endcase
        string_bytes = string_bytes + 12'(len);

        if (eoi) begin
            push_beat(8'h00, ST_OK, 1'b1);
            close_string();
        end
    endtask

    // ---------------------------------------------------------------
    // Output checking: compare every accepted beat against the oldest one due
    // ---------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_utf8_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (utf8_beats_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %0h status %0d eos %0b",
                         $time, o_out_byte, o_status, o_end_of_string);
                mismatches++;
            end else begin
                want = utf8_beats_due.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("status", want.status, o_status);
                check_field("end_of_string", want.eos, o_end_of_string);
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                // this cycle is the first of the burst
                stall_left = $urandom_range(1, 5) - 1;
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one unit and wait until it is accepted; valid stays high afterwards
    task automatic send_unit(input logic [15:0] unit, input logic eoi);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_code_unit    = unit;
        i_end_of_input = eoi;
        do @(posedge i_clk); while (o_stall);
        encode_unit(unit, eoi);
        units_sent++;
    endtask

    // Send a code point as one unit or as a surrogate pair; eoi marks its last unit
    task automatic send_code_point(input logic [20:0] cp, input logic eoi);
        logic [20:0] v;
        if (cp >= 21'h10000) begin
            v = cp - 21'h10000;
            send_unit({6'b110110, v[19:10]}, 1'b0);
            send_unit({6'b110111, v[9:0]}, eoi);
        end else begin
            send_unit(cp[15:0], eoi);
        end
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Let all due beats drain, then give units that cause none time to pass
    task automatic wait_drained();
        hold_input();
        while (utf8_beats_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [11:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random well-formed string, sometimes with a broken pair inside
    task automatic random_string();
        int          n_chars;
        bit          by_eoi;
        int          kind;
        logic        last;
        logic [20:0] cp;
        logic [15:0] r;
        n_chars = $urandom_range(0, 6);
        by_eoi  = 1'($urandom_range(0, 1));
        for (int i = 0; i < n_chars; i++) begin
            last = by_eoi && (i == n_chars - 1);
            kind = $urandom_range(0, 10);
            if (kind <= 3) begin
                cp = 21'($urandom_range(1, 16'h7f));
            end else if (kind <= 5) begin
                cp = 21'($urandom_range(16'h80, 16'h7ff));
            end else if (kind == 6) begin
                // skip over the surrogate block
                r = 16'($urandom_range(16'h0800, 16'hf7ff));
                if (r >= 16'hd800)
                    r = r + 16'h0800;
                cp = {5'b0, r};
            end else if (kind <= 8) begin
                cp = 21'($urandom_range(21'h10000, 21'h10ffff));
            end else if (kind == 9) begin
                cp = {5'b0, 6'b110111, 10'($urandom_range(0, 1023))};
            end else begin
                // high surrogate followed by anything but a low one
                send_unit({6'b110110, 10'($urandom_range(0, 1023))}, 1'b0);
                r = 16'($urandom_range(0, 16'hffff));
                if (r[15:10] == 6'b110111)
                    r[10] = 1'b0;
                cp = {5'b0, r};
            end
            send_code_point(cp, last);
        end
        if (!(by_eoi && n_chars > 0))
            send_unit(16'h0000, 1'($urandom_range(0, 1)));
    endtask

    // Random unit, biased toward the surrogate block
    task automatic noise_unit();
        logic [15:0] r;
        r = 16'($urandom_range(0, 16'hffff));
        if ($urandom_range(0, 2) == 0)
            r[15:11] = 5'b11011;
        send_unit(r, $urandom_range(0, 7) == 0);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Encoding boundaries at reset capacity: every byte length, pairs, lone low
    task automatic test_encoding();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hffff, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_code_point(21'h10000, 1'b0);
        send_code_point(21'h10ffff, 1'b1);
        send_unit(16'hdfff, 1'b0);
        send_unit(16'h0001, 1'b1);
    endtask

    // Broken pairs and a high surrogate at end of input
    task automatic test_illegal();
        send_unit(16'hd83d, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hd800, 1'b1);
    endtask

    // Too-long at zero and tiny capacity, and capacity lowered mid-string
    task automatic test_capacity();
        write_capacity(12'd0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007f, 1'b1);
        write_capacity(12'd3);
        send_unit(16'h0800, 1'b0);
        send_unit(16'h0041, 1'b1);
        write_capacity(12'd4095);
        send_unit(16'h0800, 1'b0);
        send_unit(16'h0800, 1'b0);
        write_capacity(12'd2);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0000, 1'b0);
    endtask

    // Hold the receiver off long enough to fill the block and stall its input
    task automatic test_backpressure();
        write_capacity(12'd1024);
        quiet    = 1'b1;
        hold_req = 80;
        for (int i = 0; i < 12; i++)
            send_code_point(21'h10000 + 21'(i), i == 11);
        quiet = 1'b0;
    endtask

    // Mostly well-formed strings with some noise, run to a unit count
    task automatic test_random(input logic [11:0] capacity, input int n_units);
        int stop_at;
        write_capacity(capacity);
        stop_at = units_sent + n_units;
        while (units_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                noise_unit();
            else
                random_string();
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_code_unit    = '0;
        i_end_of_input = 1'b0;
        i_stall        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        quiet          = 1'b0;
        hold_req       = 0;
        mismatches     = 0;
        units_sent     = 0;
        cap_reg        = 12'd1024;
        dropping       = 1'b0;
        close_string();

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_encoding();
        test_illegal();
        test_capacity();
        test_backpressure();
        test_random(12'd4095, 65);
        test_random(12'($urandom_range(0, 12)), 65);
        test_random(12'd1024, 65);
        test_random(12'($urandom_range(4, 20)), 65);
        // last stretch runs without idling on either side
        quiet = 1'b1;
        test_random(12'd40, 40);

        hold_input();
        while (utf8_beats_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
